### src/spw_pkg.sv
// Package for the strand position pileup window: sizes, codes, command and status types.
package spw_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int OFF_W        = IDX_W + 1;
  localparam int COUNT_BITS   = 16;
  localparam int WORD_W       = 2 * COUNT_BITS;
  localparam int CHROM_W      = 16;
  localparam int POS_W        = 31;
  localparam int HEAD_W       = 32;
  localparam int RLEN_W       = 7;
  localparam int OUT_CNT_W    = 16;

  localparam logic [RLEN_W-1:0]     RLEN_RESET = 7'd36;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  // What a decoded item asks of the window.
  typedef enum logic [2:0] {
    KIND_EOS,
    KIND_NEWCHROM,
    KIND_OPEN,
    KIND_DROP,
    KIND_ADVANCE,
    KIND_COUNT
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH,
    ST_FLUSH_RD,
    ST_DROP,
    ST_COUNT_RD,
    ST_COUNT_WR
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic walk_step;
    logic slot_read;
    logic slot_emit;
    logic drop_emit;
    logic open_win;
    logic advance;
    logic finish;
    logic count_read;
    logic count_write;
  } cmd_t;

  typedef struct packed {
    kind_t kind_now;
    kind_t kind_q;
    logic  rem_any;
    logic  slot_valid;
    logic  out_free;
  } stat_t;

  // Effective read length minus one, with the length held to 1..WINDOW_DEPTH.
  function automatic logic [IDX_W-1:0] len_minus_one(input logic [RLEN_W-1:0] rl);
    logic [RLEN_W-1:0] l;
    l = rl;
    if (l == '0) l = RLEN_W'(1);
    if (l > RLEN_W'(WINDOW_DEPTH)) l = RLEN_W'(WINDOW_DEPTH);
    return IDX_W'(l - RLEN_W'(1));
  endfunction

  // Saturate a stored count to the width of the result field.
  function automatic logic [OUT_CNT_W-1:0] clip_count(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_CNT_W-1:0] w;
    w = (COUNT_BITS + OUT_CNT_W)'(v);
    if (w > (COUNT_BITS + OUT_CNT_W)'({OUT_CNT_W{1'b1}})) return '1;
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

### src/spw_ctrl.sv
// Controller state machine for the strand position pileup window.
module spw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spw_pkg::stat_t stat,
  output spw_pkg::cmd_t  cmd
);
  import spw_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.kind_now)
          KIND_EOS, KIND_NEWCHROM, KIND_ADVANCE: state_nxt = ST_FLUSH;
          KIND_OPEN: begin
            cmd.open_win = 1'b1;
            state_nxt    = ST_COUNT_RD;
          end
          KIND_DROP:  state_nxt = ST_DROP;
          KIND_COUNT: state_nxt = ST_COUNT_RD;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_FLUSH: begin
        if (!stat.rem_any) begin
          // Nothing left to report in the range: apply the window update.
          case (stat.kind_q)
            KIND_EOS: begin
              cmd.finish = 1'b1;
              state_nxt  = ST_IDLE;
            end
            KIND_NEWCHROM: begin
              cmd.open_win = 1'b1;
              state_nxt    = ST_COUNT_RD;
            end
            KIND_ADVANCE: begin
              cmd.advance = 1'b1;
              state_nxt   = ST_COUNT_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end else if (stat.slot_valid) begin
          cmd.slot_read = 1'b1;
          state_nxt     = ST_FLUSH_RD;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_FLUSH_RD: begin
        if (stat.out_free) begin
          cmd.slot_emit = 1'b1;
          state_nxt     = ST_FLUSH;
        end
      end
      ST_DROP: begin
        if (stat.out_free) begin
          cmd.drop_emit = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_COUNT_RD: begin
        cmd.count_read = 1'b1;
        state_nxt      = ST_COUNT_WR;
      end
      ST_COUNT_WR: begin
        cmd.count_write = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_capture_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_DECODE)
    else $error("accepted item was not decoded next");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_emit |-> $past(cmd.slot_read) || $past(state_r) == ST_FLUSH_RD)
    else $error("slot emitted without a read");
`endif

endmodule

### src/spw_dpath.sv
// Datapath for the strand position pileup window: window state, count memory, result register.
module spw_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spw_pkg::cmd_t                  cmd,
  output spw_pkg::stat_t                 stat,
  input  logic                           cfg_we,
  input  logic [spw_pkg::RLEN_W-1:0]     cfg_wdata,
  input  logic [spw_pkg::CHROM_W-1:0]    in_chromosome,
  input  logic [spw_pkg::POS_W-1:0]      in_start_position,
  input  logic                           in_reverse_strand,
  input  logic                           in_end_of_stream,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spw_pkg::CHROM_W-1:0]    out_chromosome,
  output logic [spw_pkg::POS_W-1:0]      out_position,
  output logic [spw_pkg::OUT_CNT_W-1:0]  out_plus_count,
  output logic [spw_pkg::OUT_CNT_W-1:0]  out_minus_count,
  output logic                           out_dropped,
  output logic                           out_last
);
  import spw_pkg::*;

  // Configuration.
  logic [RLEN_W-1:0] rlen_r;

  // Captured item.
  logic [CHROM_W-1:0]       chrom_in_r;
  logic [POS_W-1:0]         start_r;
  logic                     rev_r;
  logic                     eos_r;
  logic [HEAD_W-1:0]        pos5_r;
  logic signed [HEAD_W:0]   nh_r;

  // Window state.
  logic [CHROM_W-1:0]       act_chrom_r;
  logic [HEAD_W-1:0]        head_r;
  logic [IDX_W-1:0]         base_r;
  logic                     started_r;
  logic [WINDOW_DEPTH-1:0]  valid_r;

  // Decode results and walk.
  kind_t                    kind_r;
  logic [OFF_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         shift_r;
  logic [OFF_W-1:0]         walk_off_r;

  // Count memory.
  logic [WORD_W-1:0]        mem [WINDOW_DEPTH];
  logic [WORD_W-1:0]        rdata_r;

  // Result register.
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [CHROM_W-1:0]       out_chrom_r;
  logic [POS_W-1:0]         out_pos_r;
  logic [OUT_CNT_W-1:0]     out_plus_r;
  logic [OUT_CNT_W-1:0]     out_minus_r;
  logic                     out_drop_r;
  logic                     out_last_r;

  logic [IDX_W-1:0]         lenm1;
  logic [HEAD_W-1:0]        pos5_in;
  logic signed [HEAD_W:0]   nh_in;
  logic                     behind;
  logic                     ahead;
  logic [HEAD_W-1:0]        shift;
  logic [OFF_W-1:0]         cnt_now;
  kind_t                    kind_now;
  logic [IDX_W-1:0]         walk_idx;
  logic [IDX_W-1:0]         cnt_idx;
  logic [WINDOW_DEPTH-1:0]  rot;
  logic [WINDOW_DEPTH-1:0]  rem;
  logic [WINDOW_DEPTH-1:0]  more;
  logic [HEAD_W-1:0]        emit_pos;
  logic [IDX_W-1:0]         mem_raddr;
  logic                     mem_re;
  logic [WORD_W-1:0]        old_word;
  logic [COUNT_BITS-1:0]    old_plus;
  logic [COUNT_BITS-1:0]    old_minus;
  logic [COUNT_BITS-1:0]    new_plus;
  logic [COUNT_BITS-1:0]    new_minus;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rlen_r <= RLEN_RESET;
    end else if (cfg_we) begin
      rlen_r <= cfg_wdata;
    end
  end

  // The 5' end and the head that would just fit it are formed while the item is taken.
  assign lenm1   = len_minus_one(rlen_r);
  assign pos5_in = {1'b0, in_start_position} + (in_reverse_strand ? HEAD_W'(lenm1) : '0);
  assign nh_in   = in_reverse_strand ? $signed({2'b00, in_start_position})
                 : $signed({2'b00, in_start_position} - (HEAD_W + 1)'(lenm1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chrom_in_r <= in_chromosome;
      start_r    <= in_start_position;
      rev_r      <= in_reverse_strand;
      eos_r      <= in_end_of_stream;
      pos5_r     <= pos5_in;
      nh_r       <= nh_in;
    end
  end

  assign behind  = pos5_r < head_r;
  assign ahead   = nh_r > $signed({1'b0, head_r});
  assign shift   = nh_r[HEAD_W-1:0] - head_r;
  assign cnt_now = (|shift[HEAD_W-1:IDX_W]) ? OFF_W'(WINDOW_DEPTH)
                                            : {1'b0, shift[IDX_W-1:0]};

  always_comb begin
    if (eos_r)                                    kind_now = KIND_EOS;
    else if (started_r && chrom_in_r != act_chrom_r) kind_now = KIND_NEWCHROM;
    else if (!started_r)                          kind_now = KIND_OPEN;
    else if (behind)                              kind_now = KIND_DROP;
    else if (ahead)                               kind_now = KIND_ADVANCE;
    else                                          kind_now = KIND_COUNT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= KIND_COUNT;
      cnt_r      <= '0;
      shift_r    <= '0;
      walk_off_r <= '0;
    end else begin
      if (cmd.decode) begin
        kind_r     <= kind_now;
        cnt_r      <= (kind_now == KIND_ADVANCE) ? cnt_now : OFF_W'(WINDOW_DEPTH);
        shift_r    <= shift[IDX_W-1:0];
        walk_off_r <= '0;
      end else if (cmd.walk_step || cmd.slot_emit) begin
        walk_off_r <= walk_off_r + OFF_W'(1);
      end
    end
  end

  assign walk_idx = base_r + walk_off_r[IDX_W-1:0];
  assign cnt_idx  = base_r + pos5_r[IDX_W-1:0] - head_r[IDX_W-1:0];

  // Valid bits seen from the head, and what is still to report in the walk range.
  always_comb begin
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      rot[j]  = valid_r[base_r + IDX_W'(j)];
      rem[j]  = rot[j] && (OFF_W'(j) >= walk_off_r) && (OFF_W'(j) < cnt_r);
      more[j] = rot[j] && (OFF_W'(j) > walk_off_r) && (OFF_W'(j) < cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_chrom_r <= '0;
      head_r      <= '0;
      base_r      <= '0;
      started_r   <= 1'b0;
    end else begin
      if (cmd.open_win) begin
        act_chrom_r <= chrom_in_r;
        head_r      <= {1'b0, start_r};
        base_r      <= '0;
        started_r   <= 1'b1;
      end else if (cmd.advance) begin
        head_r <= nh_r[HEAD_W-1:0];
        base_r <= base_r + shift_r;
      end else if (cmd.finish) begin
        base_r    <= '0;
        started_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.count_write) begin
      valid_r[cnt_idx] <= 1'b1;
    end else if (cmd.slot_emit) begin
      valid_r[walk_idx] <= 1'b0;
    end
  end

  assign mem_re    = cmd.count_read || cmd.slot_read;
  assign mem_raddr = cmd.count_read ? cnt_idx : walk_idx;

  // A slot that is not valid holds zero counts whatever the memory says.
  assign old_word  = valid_r[cnt_idx] ? rdata_r : '0;
  assign old_plus  = old_word[WORD_W-1:COUNT_BITS];
  assign old_minus = old_word[COUNT_BITS-1:0];
  assign new_plus  = (!rev_r && old_plus != COUNT_MAX) ? old_plus + COUNT_BITS'(1) : old_plus;
  assign new_minus = (rev_r && old_minus != COUNT_MAX) ? old_minus + COUNT_BITS'(1)
                                                      : old_minus;

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
    if (cmd.count_write) begin
      mem[cnt_idx] <= {new_plus, new_minus};
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign emit_pos      = head_r + HEAD_W'(walk_off_r);
  assign out_valid_nxt = (cmd.slot_emit || cmd.drop_emit) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_emit) begin
      out_chrom_r <= act_chrom_r;
      out_pos_r   <= emit_pos[POS_W-1:0];
      out_plus_r  <= clip_count(rdata_r[WORD_W-1:COUNT_BITS]);
      out_minus_r <= clip_count(rdata_r[COUNT_BITS-1:0]);
      out_drop_r  <= 1'b0;
      out_last_r  <= ~|more;
    end else if (cmd.drop_emit) begin
      out_chrom_r <= chrom_in_r;
      out_pos_r   <= pos5_r[POS_W-1:0];
      out_plus_r  <= '0;
      out_minus_r <= '0;
      out_drop_r  <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.kind_now   = kind_now;
  assign stat.kind_q     = kind_r;
  assign stat.rem_any    = |rem;
  assign stat.slot_valid = valid_r[walk_idx];
  assign stat.out_free   = out_free;

  assign out_valid       = out_valid_r;
  assign out_chromosome  = out_chrom_r;
  assign out_position    = out_pos_r;
  assign out_plus_count  = out_plus_r;
  assign out_minus_count = out_minus_r;
  assign out_dropped     = out_drop_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_last_r && out_plus_r == '0 && out_minus_r == '0)
    else $error("dropped result is not a lone empty result");

  a_emit_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_emit |-> valid_r[walk_idx])
    else $error("emitted a slot that holds no count");

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_write |-> started_r && !eos_r)
    else $error("count written outside an open window");
`endif

endmodule

### src/strand_position_pileup_window.sv
// Top level of the strand position pileup window.
//
// This block takes a coordinate-sorted stream of alignments and counts their 5' ends per
// strand in a window of read_length positions (1 to 64), reporting each position that
// leaves the window with a nonzero count, in ascending order, with saturating plus and
// minus counts. A forward read's 5' end is its start; a reverse read's is start plus
// read_length minus 1. A read whose 5' end is on the chromosome in use and past the
// window moves the head forward; a new chromosome or an end-of-stream item reports the
// whole window. A read that falls behind the head is not counted and gives a single
// result with dropped and last set. The final result caused by one input carries last.
// An input that only adds a count passes through accept, decode, memory read and memory
// write before the next transfer is taken. An item that moves the window walks the slots
// it retires one by one and reads each stored position out before reporting it; the
// walk stops early once no stored count is left in its range. The count memory is
// single-port and serves one slot per cycle. A finished result waits in an output
// register, so the walk continues while the downstream side is ready and pauses only
// while a result is still held. The user must write read_length through cfg_we and
// cfg_wdata only while the block is idle; the block itself does not enforce it. Its
// reset value is 36.
module strand_position_pileup_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spw_pkg::RLEN_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spw_pkg::CHROM_W-1:0]    in_chromosome,
  input  logic [spw_pkg::POS_W-1:0]      in_start_position,
  input  logic                           in_reverse_strand,
  input  logic                           in_end_of_stream,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spw_pkg::CHROM_W-1:0]    out_chromosome,
  output logic [spw_pkg::POS_W-1:0]      out_position,
  output logic [spw_pkg::OUT_CNT_W-1:0]  out_plus_count,
  output logic [spw_pkg::OUT_CNT_W-1:0]  out_minus_count,
  output logic                           out_dropped,
  output logic                           out_last
);
  import spw_pkg::*;

  // Commands flow from the controller to the datapath, status flows back.
  cmd_t  cmd;
  stat_t stat;

  // The controller takes a transfer through decode, window walk, drop and count update.
  spw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the window, the count memory and the result register.
  spw_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_chromosome     (in_chromosome),
    .in_start_position (in_start_position),
    .in_reverse_strand (in_reverse_strand),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_chromosome    (out_chromosome),
    .out_position      (out_position),
    .out_plus_count    (out_plus_count),
    .out_minus_count   (out_minus_count),
    .out_dropped       (out_dropped),
    .out_last          (out_last)
  );

endmodule
